/* rtl/core/lgge_pkg.sv */
`timescale 1ns / 1ps

package lgge_pkg;

  // Default grid size
  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned SIZE_W = 7;

  // APB side
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Register index (paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_ADVANCE = 2'd3
  } lgge_op_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;     // capture request, rewind counters
    logic clr_step;  // zero one row
    logic cell_upd;  // cell read data back: sample bit / write row
    logic gen_step;  // one step of the generation sweep
    logic load_out;  // move result into output register
  } lgge_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic     clr_last;
    logic     gen_last;
  } lgge_sts_t;

endpackage

/* rtl/core/lgge_ram.sv */
`timescale 1ns / 1ps

module lgge_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lgge_ctrl.sv */
`timescale 1ns / 1ps

module lgge_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lgge_pkg::lgge_cmd_t cmd,
  input  lgge_pkg::lgge_sts_t sts
);

  import lgge_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_ACC    = 6'b000100,
    ST_ACC_WB = 6'b001000,
    ST_GEN    = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   resp_pend_r, resp_pend_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    resp_pend_nxt = resp_pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch     = 1'b1;
          resp_pend_nxt = 1'b1;
          case (lgge_op_t'(in_cmd))
            OP_CLEAR:   state_nxt = ST_CLEAR;
            OP_ADVANCE: state_nxt = ST_GEN;
            default:    state_nxt = ST_ACC;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = resp_pend_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_ACC: begin
        state_nxt = ST_ACC_WB;
      end
      ST_ACC_WB: begin
        cmd.cell_upd = 1'b1;
        state_nxt    = ST_RESP;
      end
      ST_GEN: begin
        cmd.gen_step = 1'b1;
        if (sts.gen_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          resp_pend_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      resp_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      resp_pend_r <= resp_pend_nxt;
    end
  end

endmodule

/* rtl/core/lgge_dp.sv */
`timescale 1ns / 1ps

module lgge_dp #(
  parameter int unsigned MAX_ROWS = lgge_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = lgge_pkg::DEF_MAX_COLS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_cmd,
  input  logic [5:0]          in_row_index,
  input  logic [5:0]          in_col_index,
  input  logic                in_cell_value,
  output logic                out_cell_read,
  output logic                out_address_error,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  lgge_pkg::lgge_cmd_t cmd,
  output lgge_pkg::lgge_sts_t sts
);

  import lgge_pkg::*;

  localparam int unsigned RAW = $clog2(MAX_ROWS);
  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW = $clog2(MAX_COLS + 1);
  localparam int unsigned KW  = $clog2(MAX_ROWS + 2);
  localparam int unsigned RSW = (NRW > SIZE_W) ? NRW : SIZE_W;
  localparam int unsigned CSW = (NCW > SIZE_W) ? NCW : SIZE_W;
  localparam int unsigned RCW = (NRW > IDX_W) ? NRW : IDX_W;
  localparam int unsigned CCW = (NCW > IDX_W) ? NCW : IDX_W;

  // Size registers
  logic [SIZE_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [NRW-1:0]    nrows;
  logic [NCW-1:0]    ncols;

  // Latched request
  lgge_op_t         op_r;
  logic [IDX_W-1:0] row_r, col_r;
  logic             val_r;
  logic             addr_err;

  // Counters
  logic [RAW-1:0] clr_cnt_r;
  logic [KW-1:0]  gen_cnt_r;

  // Sweep row buffers (old copies)
  logic [MAX_COLS-1:0] above_r, cur_r;
  logic [MAX_COLS-1:0] below, col_mask, life_row, new_row;

  // Cell access
  logic [MAX_COLS-1:0] rd_data, rd_shift, bit_sel, upd_row;
  logic                bit_r;

  // Output register
  logic out_read_r, out_err_r;

  // RAM ports
  logic                ram_we;
  logic [RAW-1:0]      ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata;

  logic below_ok, gen_wr;
  logic [MAX_COLS+1:0] ap, cp, bp;
  logic [3:0]          nsum;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= SIZE_RESET;
      cols_cfg_r <= SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ROWS: rows_cfg_r <= pwdata[SIZE_W-1:0];
        REG_COLS: cols_cfg_r <= pwdata[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = PDATA_W'(rows_cfg_r);
      REG_COLS: prdata = PDATA_W'(cols_cfg_r);
      default:  prdata = '0;
    endcase
  end

  // Effective size: zero reads as one, large values saturate
  always_comb begin
    if (rows_cfg_r == '0) begin
      nrows = NRW'(1);
    end else if (RSW'(rows_cfg_r) > RSW'(MAX_ROWS)) begin
      nrows = NRW'(MAX_ROWS);
    end else begin
      nrows = NRW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      ncols = NCW'(1);
    end else if (CSW'(cols_cfg_r) > CSW'(MAX_COLS)) begin
      ncols = NCW'(MAX_COLS);
    end else begin
      ncols = NCW'(cols_cfg_r);
    end
  end

  // ---- request capture and counters ----
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= lgge_op_t'(in_cmd);
      row_r <= in_row_index;
      col_r <= in_col_index;
      val_r <= in_cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      gen_cnt_r <= '0;
    end else if (cmd.latch) begin
      clr_cnt_r <= '0;
      gen_cnt_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + RAW'(1);
      end
      if (cmd.gen_step) begin
        gen_cnt_r <= gen_cnt_r + KW'(1);
      end
    end
  end

  assign addr_err = (RCW'(row_r) >= RCW'(nrows)) || (CCW'(col_r) >= CCW'(ncols));

  assign sts.clr_last = (clr_cnt_r == RAW'(MAX_ROWS - 1));
  assign sts.gen_last = (gen_cnt_r == KW'(nrows) + KW'(1));

  // ---- generation step ----
  // gen_cnt = k: row k is being read, rd_data holds old row k-1,
  // row k-2 gets its new value.
  assign below_ok = (gen_cnt_r - KW'(1)) < KW'(nrows);
  assign below    = below_ok ? rd_data : '0;
  assign gen_wr   = cmd.gen_step && (gen_cnt_r >= KW'(2));

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (NCW'(c) < ncols);
    end
  end

  always_comb begin
    nsum = '0;
    ap   = {1'b0, above_r & col_mask, 1'b0};
    cp   = {1'b0, cur_r & col_mask, 1'b0};
    bp   = {1'b0, below & col_mask, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      nsum = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
           + 4'(cp[c]) + 4'(cp[c+2])
           + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
      life_row[c] = (nsum == 4'd3) || (cp[c+1] && (nsum == 4'd2));
    end
  end

  // Columns outside the active area keep their value
  assign new_row = (life_row & col_mask) | (cur_r & ~col_mask);

  always_ff @(posedge clk) begin
    if (cmd.gen_step && (gen_cnt_r != '0)) begin
      if (gen_cnt_r == KW'(1)) begin
        above_r <= '0;
      end else begin
        above_r <= cur_r;
      end
      cur_r <= below;
    end
  end

  // ---- cell access ----
  assign rd_shift = rd_data >> col_r;
  assign bit_sel  = MAX_COLS'(1) << col_r;
  assign upd_row  = val_r ? (rd_data | bit_sel) : (rd_data & ~bit_sel);

  always_ff @(posedge clk) begin
    if (cmd.cell_upd) begin
      bit_r <= rd_shift[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_r <= (op_r == OP_READ) && !addr_err && bit_r;
      out_err_r  <= ((op_r == OP_READ) || (op_r == OP_WRITE)) && addr_err;
    end
  end

  assign out_cell_read     = out_read_r;
  assign out_address_error = out_err_r;

  // ---- grid memory ----
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = RAW'(row_r);
    ram_wdata = upd_row;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (gen_wr) begin
      ram_we    = 1'b1;
      ram_waddr = RAW'(gen_cnt_r - KW'(2));
      ram_wdata = new_row;
    end else if (cmd.cell_upd && (op_r == OP_WRITE) && !addr_err) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd.gen_step ? RAW'(gen_cnt_r) : RAW'(row_r);

  lgge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

endmodule

/* rtl/core/life_grid_generation_engine.sv */
`timescale 1ns / 1ps
// Cell write/read: latch request, read the row, sample the bit or write it, load
// the result. Clear zeroes every grid row. Advance sweeps one grid row per cycle
// through the row RAM, read two rows ahead of the write; out_stall holds results.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset: synchronous, active low. After reset a clearing pass zeroes the grid
// with in_stall high; size registers return to 64.

module life_grid_generation_engine #(
  parameter int unsigned MAX_ROWS = lgge_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = lgge_pkg::DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic        in_cell_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cell_read,
  output logic        out_address_error,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import lgge_pkg::*;

  lgge_cmd_t cmd;
  lgge_sts_t sts;

  // Zero wait state register access
  assign pready = 1'b1;

  // Sequencer: decodes the request, runs the clear sweep, the cell
  // read/modify/write and the generation sweep, and owns out_valid.
  lgge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: size registers, grid RAM (one row per word), the two old-row
  // buffers of the in-place sweep, the B3/S23 neighbor logic for a whole row,
  // and the result register.
  lgge_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_cell_value     (in_cell_value),
    .out_cell_read     (out_cell_read),
    .out_address_error (out_address_error),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
